FILE: src/ltc_pkg.sv
// Package for the line token classifier: token categories, scanner modes,
// the queued token word and the character and keyword helper functions.
// Depends on nothing; every other file imports it.
`default_nettype none

package ltc_pkg;

  typedef enum logic [3:0] {
    CAT_COMMENT  = 4'd0,
    CAT_INDENT   = 4'd1,
    CAT_REL      = 4'd2,
    CAT_ARITH    = 4'd3,
    CAT_LOGICAL  = 4'd4,
    CAT_KEYWORD  = 4'd5,
    CAT_IDENT    = 4'd6,
    CAT_ASSIGN   = 4'd7,
    CAT_LPAREN   = 4'd8,
    CAT_RPAREN   = 4'd9,
    CAT_COLON    = 4'd10,
    CAT_COMMA    = 4'd11,
    CAT_NUMBER   = 4'd12,
    CAT_STRING   = 4'd13,
    CAT_UNKNOWN  = 4'd14,
    CAT_LINE_END = 4'd15
  } ltc_cat_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_INDENT,
    M_WORD,
    M_NUMBER,
    M_COMMENT,
    M_STRING,
    M_REL,
    M_EQ
  } ltc_mode_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    ltc_cat_t    cat;
    logic [7:0]  start;
    logic [7:0]  len;
    logic        last;
  } ltc_tok_t;

  // Keywords are compared on the first five bytes, first byte lowest.
  localparam int unsigned KW_CMP_CHARS = 5;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09);
  endfunction

  // Saturate a zero-extended column or count to one byte.
  function automatic logic [7:0] sat8(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  // Bytes past the word length are zero, so a zero-padded compare plus a
  // length bound identifies the word exactly.
  function automatic ltc_cat_t word_cat(input logic [39:0] w, input logic [7:0] n);
    ltc_cat_t cat;
    cat = CAT_IDENT;
    if (n <= 8'(KW_CMP_CHARS)) begin
      case (w)
        40'h00_00_64_6E_61,                      // and
        40'h00_00_00_72_6F,                      // or
        40'h00_00_74_6F_6E,                      // not
        40'h00_00_00_6E_69: cat = CAT_LOGICAL;   // in
        40'h74_6E_69_72_70,                      // print
        40'h00_00_00_66_69,                      // if
        40'h00_66_69_6C_65,                      // elif
        40'h00_65_73_6C_65,                      // else
        40'h65_6C_69_68_77,                      // while
        40'h00_00_74_6E_69,                      // int
        40'h74_75_70_6E_69,                      // input
        40'h00_00_72_6F_66,                      // for
        40'h65_67_6E_61_72: cat = CAT_KEYWORD;   // range
        default: cat = CAT_IDENT;
      endcase
    end
    return cat;
  endfunction

  // Category reported when an open token is closed.
  function automatic ltc_cat_t close_cat(input ltc_mode_t m, input logic [39:0] w,
                                         input logic [7:0] n);
    ltc_cat_t cat;
    case (m)
      M_INDENT:  cat = CAT_INDENT;
      M_WORD:    cat = word_cat(w, n);
      M_NUMBER:  cat = CAT_NUMBER;
      M_COMMENT: cat = CAT_COMMENT;
      M_STRING:  cat = CAT_STRING;
      M_REL:     cat = CAT_REL;
      M_EQ:      cat = CAT_ASSIGN;
      default:   cat = CAT_IDENT;
    endcase
    return cat;
  endfunction

endpackage

`default_nettype wire

FILE: src/line_token_classifier.sv
// Line token classifier top level: input register, scanner state update and
// a four-word result queue that drives the output stream.
// Depends on ltc_pkg.
//
// Usage:
//   Input stream: one source character per word. in_tdata carries the byte,
//   in_tuser[0] says the byte is present (0 for an empty line) and in_tlast
//   ends the line. Output stream: one token per word, out_tuser holds the
//   category, out_tdata the start column and length, out_tlast marks the
//   final token caused by one input word. Every line closes with a line-end
//   token whose start column is the line's character count.
//   Path: an accepted word is held in the input register, scanned from there
//   and its tokens pushed into the queue, whose head drives the output.
//   Throughput: one input word per cycle while each word causes one token
//   and out_tready stays high. The scanner runs once per cycle on the input
//   register and pushes up to three tokens into the queue; it runs only while
//   at most one token is queued, so the single output port sets the rate.
//   Reset: clears the scanner to idle at column 0 and empties the queue.
//   Stall: with out_tready low, the head token holds; the queue fills and
//   in_tready drops once the input register holds a word that cannot be
//   scanned. No word is lost or repeated.
`default_nettype none

module line_token_classifier #(
  parameter int unsigned MAX_LINE      = 256,
  parameter int unsigned KEYWORD_CHARS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic [0:0]  in_tuser,   // [0] has_char
  input  wire logic        in_tlast,   // end_of_line
  // output stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [7:0] start_column, [15:8] token_length
  output      logic [3:0]  out_tuser,  // [3:0] category
  output      logic        out_tlast   // last
);
  import ltc_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned KW_IDX = $clog2(KEYWORD_CHARS);
  localparam int unsigned WB_W   = 8 * KEYWORD_CHARS;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // token as produced by the scanner, before the last flag is attached
  typedef struct packed {
    ltc_cat_t   cat;
    logic [7:0] start;
    logic [7:0] len;
  } scan_res_t;

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_has_r;
  logic       in_eol_r;

  // scanner state
  ltc_mode_t        mode_r, mode_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] start_r, start_nxt;
  logic [7:0]       tcnt_r, tcnt_nxt;
  logic [WB_W-1:0]  wbuf_r, wbuf_nxt;
  logic             qdbl_r, qdbl_nxt;

  // result queue
  ltc_tok_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] q_head_r, q_tail_r;
  logic [QCNT_W-1:0] q_cnt_r;

  scan_res_t  res [3];
  logic [1:0] nres;
  logic       proc;
  logic       pop;
  logic       take;
  logic       consumed;
  logic       closing;
  logic [7:0] c;
  logic [7:0] col_sat;

  // scan the held word only when three queue slots are free
  assign proc      = in_v_r && (q_cnt_r <= QCNT_W'(1));
  assign in_tready = !in_v_r || proc;
  assign pop       = out_tvalid && out_tready;

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = q_mem_r[q_head_r].cat;
  assign out_tdata  = {q_mem_r[q_head_r].len, q_mem_r[q_head_r].start};
  assign out_tlast  = q_mem_r[q_head_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_has_r  <= in_tuser[0];
      in_eol_r  <= in_tlast;
    end
  end

  // Scanner: close what the character ends, then classify it, then handle
  // the line end. Up to three tokens come out of one word.
  always_comb begin
    mode_nxt  = mode_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    tcnt_nxt  = tcnt_r;
    wbuf_nxt  = wbuf_r;
    qdbl_nxt  = qdbl_r;
    nres      = 2'd0;
    res       = '{default: '0};
    consumed  = 1'b0;
    closing   = 1'b0;
    c         = in_char_r;
    col_sat   = sat8(16'(col_r));
    take      = in_has_r && (col_r < COL_W'(MAX_LINE));

    if (take) begin
      case (mode_r)
        M_INDENT: begin
          if (is_blank(c)) begin
            consumed = 1'b1;
            if (tcnt_nxt != 8'hFF) tcnt_nxt = tcnt_nxt + 8'd1;
          end else begin
            closing = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c)) begin
            consumed = 1'b1;
            if (tcnt_nxt < 8'(KEYWORD_CHARS)) begin
              wbuf_nxt[8*tcnt_nxt[KW_IDX-1:0] +: 8] = c;
            end
            if (tcnt_nxt != 8'hFF) tcnt_nxt = tcnt_nxt + 8'd1;
          end else begin
            closing = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            consumed = 1'b1;
            if (tcnt_nxt != 8'hFF) tcnt_nxt = tcnt_nxt + 8'd1;
          end else begin
            closing = 1'b1;
          end
        end
        M_COMMENT: begin
          consumed = 1'b1;
          if (tcnt_nxt != 8'hFF) tcnt_nxt = tcnt_nxt + 8'd1;
        end
        M_STRING: begin
          consumed = 1'b1;
          if (tcnt_nxt != 8'hFF) tcnt_nxt = tcnt_nxt + 8'd1;
          if (c == (qdbl_r ? 8'h22 : 8'h27)) begin
            res[nres] = '{CAT_STRING, sat8(16'(start_r)), tcnt_nxt};
            nres      = nres + 2'd1;
            mode_nxt  = M_IDLE;
          end
        end
        M_REL, M_EQ: begin
          if (c == "=") begin
            consumed  = 1'b1;
            res[nres] = '{CAT_REL, sat8(16'(start_r)), 8'd2};
            nres      = nres + 2'd1;
            mode_nxt  = M_IDLE;
          end else begin
            closing = 1'b1;
          end
        end
        default: ;
      endcase

      if (closing) begin
        res[nres] = '{close_cat(mode_r, wbuf_r[39:0], tcnt_r), sat8(16'(start_r)),
                      ((mode_r == M_REL) || (mode_r == M_EQ)) ? 8'd1 : tcnt_r};
        nres      = nres + 2'd1;
        mode_nxt  = M_IDLE;
      end

      if (!consumed) begin
        case (c) inside
          "#": begin
            mode_nxt = M_COMMENT; start_nxt = col_r; tcnt_nxt = 8'd1;
          end
          " ", 8'h09: begin
            if (col_r == '0) begin
              mode_nxt = M_INDENT; start_nxt = col_r; tcnt_nxt = 8'd1;
            end
          end
          "<", ">", "!": begin
            mode_nxt = M_REL; start_nxt = col_r; tcnt_nxt = 8'd1;
          end
          "=": begin
            mode_nxt = M_EQ; start_nxt = col_r; tcnt_nxt = 8'd1;
          end
          "+", "-", "*", "/", "%": begin
            res[nres] = '{CAT_ARITH, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
          ["a":"z"], ["A":"Z"]: begin
            mode_nxt      = M_WORD;
            start_nxt     = col_r;
            tcnt_nxt      = 8'd1;
            wbuf_nxt      = '0;
            wbuf_nxt[7:0] = c;
          end
          "(": begin
            res[nres] = '{CAT_LPAREN, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
          ")": begin
            res[nres] = '{CAT_RPAREN, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
          ":": begin
            res[nres] = '{CAT_COLON, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
          ",": begin
            res[nres] = '{CAT_COMMA, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
          ["0":"9"]: begin
            mode_nxt = M_NUMBER; start_nxt = col_r; tcnt_nxt = 8'd1;
          end
          8'h22, 8'h27: begin
            mode_nxt  = M_STRING;
            start_nxt = col_r;
            tcnt_nxt  = 8'd1;
            qdbl_nxt  = (c == 8'h22);
          end
          8'h0A, 8'h0D, 8'h0B, 8'h0C: ;  // skip other white space
          default: begin
            res[nres] = '{CAT_UNKNOWN, col_sat, 8'd1};
            nres      = nres + 2'd1;
          end
        endcase
      end

      col_nxt = col_r + COL_W'(1);
    end

    if (in_eol_r) begin
      if (mode_nxt != M_IDLE) begin
        res[nres] = '{close_cat(mode_nxt, wbuf_nxt[39:0], tcnt_nxt), sat8(16'(start_nxt)),
                      ((mode_nxt == M_REL) || (mode_nxt == M_EQ)) ? 8'd1 : tcnt_nxt};
        nres      = nres + 2'd1;
        mode_nxt  = M_IDLE;
      end
      res[nres] = '{CAT_LINE_END, sat8(16'(col_nxt)), 8'd0};
      nres      = nres + 2'd1;
      col_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      col_r   <= '0;
      start_r <= '0;
      tcnt_r  <= '0;
      wbuf_r  <= '0;
      qdbl_r  <= 1'b0;
    end else if (proc) begin
      mode_r  <= mode_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      tcnt_r  <= tcnt_nxt;
      wbuf_r  <= wbuf_nxt;
      qdbl_r  <= qdbl_nxt;
    end
  end

  // Queue: push this word's tokens in order, flag the final one.
  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) begin
          q_mem_r[q_tail_r + QPTR_W'(i)] <= '{res[i].cat, res[i].start, res[i].len,
                                              (2'(i) == (nres - 2'd1))};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (pop) q_head_r <= q_head_r + QPTR_W'(1);
      if (proc) q_tail_r <= q_tail_r + QPTR_W'(nres);
      q_cnt_r <= q_cnt_r + (proc ? QCNT_W'(nres) : '0) - (pop ? QCNT_W'(1) : '0);
    end
  end

endmodule

`default_nettype wire

FILE: src/ltc_checker.sv
// Port-level checker for the line token classifier, bound to the top level.
// Depends on ltc_pkg and line_token_classifier.
`default_nettype none

module ltc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);
  import ltc_pkg::*;

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // a line end is always the final token of its input word
  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CAT_LINE_END) |-> out_tlast)
    else $error("line end without tlast");

  a_eol_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CAT_LINE_END) |-> (out_tdata[15:8] == 8'd0))
    else $error("line end with nonzero length");

  a_tok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != CAT_LINE_END) |-> (out_tdata[15:8] != 8'd0))
    else $error("token with zero length");

endmodule

bind line_token_classifier ltc_checker u_ltc_checker (.*);

`default_nettype wire

FILE: tb/tb_line_token_classifier.sv
// Testbench for the line token classifier: streams source characters in, one per word,
// and checks every token against a cycle-free scanner model kept in this file.
// Depends on ltc_pkg (categories, scanner modes, token word) and line_token_classifier.
module tb_line_token_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import ltc_pkg::*;

  localparam int LINE_CAP     = 256;   // characters kept per line
  localparam int KW_LEN_MAX   = 5;     // longest word that can be a keyword
  localparam int KW_COUNT     = 13;
  localparam int LOGIC_WORDS  = 4;     // first entries of the word list are logical
  localparam int RAND_WORDS   = 460;
  localparam int WAIT_MAX     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 120;   // tokens seen before the long hold-off
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;

  // One input word as it waits to be driven.
  typedef struct packed {
    logic [7:0] code;
    logic       has;
    logic       eol;
  } src_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_code
  logic [0:0]  in_tuser   = '0;   // [0] has_char
  logic        in_tlast   = 1'b0; // end_of_line
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] start_column, [15:8] token_length
  logic [3:0]  out_tuser;         // [3:0] category
  logic        out_tlast;         // last

  line_token_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scanner model. Its state starts at the reset values; reset is applied once.
  // ---------------------------------------------------------------------------
  ltc_mode_t lex_mode  = M_IDLE;
  int        lex_col   = 0;
  int        lex_start = 0;
  int        lex_count = 0;
  string     lex_word  = "";      // first KW_LEN_MAX letters of the open word
  logic      lex_dq    = 1'b0;    // open string began with a double quote
  ltc_tok_t  step_toks[$];        // tokens caused by the word being scanned
  ltc_tok_t  tokens_due[$];       // tokens still owed by the block, oldest first

  // Fixed word list: the logical words come first, then the keywords.
  function automatic string kw_text(input int i);
    case (i)
      0:       return "and";
      1:       return "or";
      2:       return "not";
      3:       return "in";
      4:       return "print";
      5:       return "if";
      6:       return "elif";
      7:       return "else";
      8:       return "while";
      9:       return "int";
      10:      return "input";
      11:      return "for";
      default: return "range";
    endcase
  endfunction

  function automatic logic [7:0] clip8(input int v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space_or_tab(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  // A word of up to KW_LEN_MAX letters is held whole, so a plain string
  // compare also checks the length.
  function automatic ltc_cat_t classify_word(input string w, input int n);
    ltc_cat_t cat;
    cat = CAT_IDENT;
    if (n <= KW_LEN_MAX)
      for (int i = 0; i < KW_COUNT; i++)
        if (w == kw_text(i)) cat = (i < LOGIC_WORDS) ? CAT_LOGICAL : CAT_KEYWORD;
    return cat;
  endfunction

  // Record one token; a word never causes more than three.
  function automatic void add_tok(input ltc_cat_t cat, input int start, input int len);
    ltc_tok_t t;
    if (step_toks.size() >= 3) return;
    t.cat   = cat;
    t.start = clip8(start);
    t.len   = clip8(len);
    t.last  = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void lengthen();
    if (lex_count < 255) lex_count++;
  endfunction

  function automatic void open_tok(input ltc_mode_t m, input int col);
    lex_mode  = m;
    lex_start = col;
    lex_count = 1;
  endfunction

  // Report the open token, if any, and go back to idle.
  function automatic void close_token();
    case (lex_mode)
      M_INDENT:  add_tok(CAT_INDENT, lex_start, lex_count);
      M_WORD:    add_tok(classify_word(lex_word, lex_count), lex_start, lex_count);
      M_NUMBER:  add_tok(CAT_NUMBER, lex_start, lex_count);
      M_COMMENT: add_tok(CAT_COMMENT, lex_start, lex_count);
      M_STRING:  add_tok(CAT_STRING, lex_start, lex_count);
      M_REL:     add_tok(CAT_REL, lex_start, 1);
      M_EQ:      add_tok(CAT_ASSIGN, lex_start, 1);
      default:   ;
    endcase
    lex_mode = M_IDLE;
  endfunction

  function automatic void scan_char(input logic [7:0] c, input int col);
    // First let the open token take the character or close it.
    case (lex_mode)
      M_INDENT: begin
        if (is_space_or_tab(c)) begin
          lengthen();
          return;
        end
        close_token();
      end
      M_WORD: begin
        if (is_letter(c)) begin
          if (lex_count < KW_LEN_MAX) lex_word = $sformatf("%s%c", lex_word, c);
          lengthen();
          return;
        end
        close_token();
      end
      M_NUMBER: begin
        if (is_numeral(c)) begin
          lengthen();
          return;
        end
        close_token();
      end
      M_COMMENT: begin
        lengthen();
        return;
      end
      M_STRING: begin
        lengthen();
        if (c == (lex_dq ? CH_DQ : CH_SQ)) close_token();
        return;
      end
      M_REL, M_EQ: begin
        // a directly following '=' makes a two-character comparison
        if (c == "=") begin
          add_tok(CAT_REL, lex_start, 2);
          lex_mode = M_IDLE;
          return;
        end
        close_token();
      end
      default: ;
    endcase

    // Then start whatever the character begins.
    if (c == "#") open_tok(M_COMMENT, col);
    else if (is_space_or_tab(c)) begin
      if (col == 0) open_tok(M_INDENT, col);
    end
    else if (c == "<" || c == ">" || c == "!") open_tok(M_REL, col);
    else if (c == "=") open_tok(M_EQ, col);
    else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%")
      add_tok(CAT_ARITH, col, 1);
    else if (is_letter(c)) begin
      open_tok(M_WORD, col);
      lex_word = $sformatf("%c", c);
    end
    else if (c == "(") add_tok(CAT_LPAREN, col, 1);
    else if (c == ")") add_tok(CAT_RPAREN, col, 1);
    else if (c == ":") add_tok(CAT_COLON, col, 1);
    else if (c == ",") add_tok(CAT_COMMA, col, 1);
    else if (is_numeral(c)) open_tok(M_NUMBER, col);
    else if (c == CH_SQ || c == CH_DQ) begin
      open_tok(M_STRING, col);
      lex_dq = (c == CH_DQ);
    end
    else if (c == CH_LF || c == CH_CR || c == CH_VT || c == CH_FF) ;  // skip
    else add_tok(CAT_UNKNOWN, col, 1);
  endfunction

  // Work out the tokens one accepted input word causes and queue them.
  function automatic void scan_source_word(input src_word_t w);
    ltc_tok_t t;
    step_toks.delete();
    // characters past the line capacity are dropped and do not advance the column
    if (w.has && lex_col < LINE_CAP) begin
      scan_char(w.code, lex_col);
      lex_col++;
    end
    if (w.eol) begin
      close_token();
      add_tok(CAT_LINE_END, lex_col, 0);
      lex_col = 0;
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.insert(step_toks.size(), t);
    end
    foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction: lines are built in a byte buffer, then queued as words.
  // ---------------------------------------------------------------------------
  src_word_t  send_q[$];
  logic [7:0] line_buf[$];
  int         words_made = 0;

  function automatic int pick_wait();
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic void put_char(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic void push_word(input logic [7:0] c, input logic has, input logic eol);
    src_word_t w;
    w.code = c;
    w.has  = has;
    w.eol  = eol;
    send_q.insert(send_q.size(), w);
    if (has || eol) words_made++;
  endfunction

  // Queue the buffered line, end flag on its last character. An empty buffer
  // becomes an empty line. With noise on, ignored words are mixed in.
  function automatic void send_line(input logic noisy);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(line_buf[i], 1'b1, i == line_buf.size() - 1);
    end
    if (line_buf.size() == 0) push_word(8'($urandom), 1'b0, 1'b1);
    line_buf.delete();
  endfunction

  function automatic void put_token();
    int         n;
    string      kw;
    string      ops;
    string      punct;
    string      odd;
    logic [7:0] q;
    logic [7:0] c;
    ops   = "<>!=+-*/%";
    punct = "(),:";
    odd   = "$.;[]{}@^&|~?\\";
    case ($urandom_range(0, 9))
      0, 1: put_text(kw_text($urandom_range(0, KW_COUNT - 1)));
      2: begin
        // near misses of keywords: cut short, run on, capitalized
        kw = kw_text($urandom_range(0, KW_COUNT - 1));
        case ($urandom_range(0, 2))
          0: put_text(kw.substr(0, kw.len() - 2));
          1: begin
            put_text(kw);
            put_char(rand_letter());
          end
          default: begin
            put_char(kw[0] - 8'h20);
            put_text(kw.substr(1, kw.len() - 1));
          end
        endcase
      end
      3: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        repeat (n) put_char(rand_letter());
      end
      4: repeat ($urandom_range(1, 4)) put_char(8'h30 + 8'($urandom_range(0, 9)));
      5: begin
        put_char(ops[$urandom_range(0, ops.len() - 1)]);
        if ($urandom_range(0, 1)) put_char("=");
      end
      6: put_char(punct[$urandom_range(0, punct.len() - 1)]);
      7: begin
        q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
        put_char(q);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(32, 126));
          put_char((c == q) ? 8'h78 : c);
        end
        if ($urandom_range(0, 4) != 0) put_char(q);   // leave some open
      end
      8: begin
        case ($urandom_range(0, 5))
          0:       put_char(CH_SP);
          1:       put_char(CH_TAB);
          2:       put_char(CH_LF);
          3:       put_char(CH_CR);
          4:       put_char(CH_VT);
          default: put_char(CH_FF);
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       put_char(8'($urandom_range(128, 255)));
          1:       put_char(8'($urandom_range(0, 8)));
          2:       put_char(8'($urandom_range(14, 31)));
          3:       put_char(8'h7F);
          default: put_char(odd[$urandom_range(0, odd.len() - 1)]);
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed lines with random content; some empty and some garbage.
  function automatic void put_line();
    int kind;
    kind = $urandom_range(0, 11);
    if (kind == 1) begin
      repeat ($urandom_range(1, 12)) put_char(8'($urandom));
    end else if (kind != 0) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) put_char($urandom_range(0, 1) ? CH_SP : CH_TAB);
      repeat ($urandom_range(1, 7)) begin
        put_token();
        // no separator lets neighbors run together
        case ($urandom_range(0, 3))
          0:       ;
          1, 2:    put_char(CH_SP);
          default: put_char(CH_TAB);
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        put_char("#");
        repeat ($urandom_range(0, 10)) put_char(8'($urandom));
      end
    end
    send_line(1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued words, hold each until taken, pause between them.
  // ---------------------------------------------------------------------------
  src_word_t cur_word;
  int        tx_gap  = 0;
  logic      tx_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) scan_source_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur_word = send_q.pop_front();
          in_tdata  <= cur_word.code;
          in_tuser  <= cur_word.has;
          in_tlast  <= cur_word.eol;
          in_tvalid <= 1'b1;
          // switch now and then between idling and back-to-back runs
          if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
          tx_gap = tx_calm ? 0 : pick_wait();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take tokens with random stalls, one long hold-off, compare fields.
  // ---------------------------------------------------------------------------
  ltc_tok_t want;
  int       toks_seen  = 0;
  int       fail_count = 0;
  int       rx_wait    = 0;
  int       hold_left  = 0;
  logic     hold_done  = 1'b0;
  logic     rx_calm    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        toks_seen++;
        if (tokens_due.size() == 0) begin
          $error("token %0d arrived with nothing owed: category %0d start %0d length %0d",
                 toks_seen, out_tuser, out_tdata[7:0], out_tdata[15:8]);
          fail_count++;
        end else begin
          want = tokens_due.pop_front();
          if (out_tuser !== want.cat) begin
            $error("token %0d category: expected %0d, got %0d", toks_seen, want.cat, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== want.start) begin
            $error("token %0d start_column: expected %0d, got %0d",
                   toks_seen, want.start, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[15:8] !== want.len) begin
            $error("token %0d token_length: expected %0d, got %0d",
                   toks_seen, want.len, out_tdata[15:8]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("token %0d last: expected %0d, got %0d", toks_seen, want.last, out_tlast);
            fail_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : pick_wait();
      end
      // once, hold off long enough for the block to fill and stall its input
      if (!hold_done && toks_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles, %0d tokens still owed",
               quiet_cycles, tokens_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int   goal;
    logic long_done;
    long_done = 1'b0;

    // Directed: an ignored word, then an empty line, both with extreme codes.
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);
    // Mixed blank indent, word, '<=' comparison, parens, number, comment at line end.
    put_text("\t x<=(12)#");
    send_line(1'b0);
    // Lone '=', skipped blank and line feed, colon, high bytes as unknown, a closed
    // double-quoted string holding a single quote, comma, arithmetic, and a lone
    // '!' closed by ')' on the line end so one word causes three tokens.
    put_text("= ");
    put_char(CH_LF);
    put_text(":");
    put_char(8'h80);
    put_char(8'hFF);
    put_text("\"a'\",+!)");
    send_line(1'b0);

    // Random lines, with one overlong comment line halfway through: its length
    // saturates and the characters past the line capacity are dropped.
    goal = words_made + RAND_WORDS;
    while (words_made < goal) begin
      if (!long_done && words_made > goal - RAND_WORDS / 2) begin
        long_done = 1'b1;
        put_char("#");
        repeat (LINE_CAP + 5) put_char(8'($urandom));
        send_line(1'b0);
      end else begin
        put_line();
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken, then for every owed token.
    while (send_q.size() != 0 || in_tvalid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    // let any stray extra token show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && tokens_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
